@@ hw/rtl/pp_pkg.sv @@
// Shared types, constants and field helpers for the pinhole point projection block.
`default_nettype none

package pp_pkg;

	// Configuration register layout: three 21-bit signed fields, x in the low bits.
	localparam int CFG_W     = 63;
	localparam int FLD_W     = 21;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER = 2'd3;

	localparam logic [CFG_W-1:0] CENTER_RST = 63'd0;
	localparam logic [CFG_W-1:0] AXIS_A_RST = 63'd32768;
	localparam logic [CFG_W-1:0] AXIS_B_RST = 63'd4329327034368;
	localparam logic [CFG_W-1:0] CORNER_RST = 63'd0;

	// Item kinds.
	localparam logic KIND_PROJECT   = 1'b0;
	localparam logic KIND_UNPROJECT = 1'b1;

	// Coordinate and datapath widths.
	localparam int COORD_W         = 32;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int CTR_SH          = 8;
	localparam int OFF_W           = FLD_W + CTR_SH;
	localparam int D_W             = COORD_W + 1;
	localparam int BC_W            = 44;
	localparam int BC_LO           = 22;
	localparam int CR_W            = 56;
	localparam int CR_LO           = 28;
	localparam int ACC_W           = 80;
	localparam int UP_W            = 57;
	localparam int UP_SH           = 24;
	localparam int NX_SH           = 24;
	localparam int DET_SH          = 25;
	localparam int NUM_W           = 104;
	localparam int DEN_W           = 80;
	localparam int QUO_W           = 32;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} item_t;

	typedef struct packed {
		logic                      visible;
		logic                      error;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
	} result_t;

	// Camera registers plus the precomputed cross product b x c.
	typedef struct packed {
		logic [CFG_W-1:0]    center;
		logic [CFG_W-1:0]    axis_a;
		logic [CFG_W-1:0]    axis_b;
		logic [CFG_W-1:0]    corner;
		logic [3*BC_W-1:0]   bc;
	} cam_t;

	// Per-item flags that ride alongside the divider lanes.
	typedef struct packed {
		logic kind;
		logic vis;
		logic err;
		logic zero;
	} side_t;

	// One divider lane: magnitude numerator, magnitude denominator, result sign.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_in_t;

	function automatic logic signed [FLD_W-1:0] fld(input logic [CFG_W-1:0] r,
		input logic [1:0] i);
		return $signed(r[FLD_W*i +: FLD_W]);
	endfunction

	// Center coordinate rescaled to Q16.16.
	function automatic logic signed [OFF_W-1:0] ctr_off(input logic [CFG_W-1:0] r,
		input logic [1:0] i);
		return $signed({fld(r, i), {CTR_SH{1'b0}}});
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pinhole_point_project.sv @@
// Top level of the pinhole camera projection block: config, front end, divider, output stage.
//
// Use: load the camera with cfg_wr_en/cfg_index/cfg_data while no beat is in flight:
// index 0 is the center, 1 and 2 the pixel axes a and b, 3 the corner vector c.
// Each item beat on the item channel (kind 0 project, kind 1 unproject) produces exactly
// one result beat on the result channel, in order. A beat moves when valid is high and
// stall is low.
// From the accepting edge to result_valid each beat passes through five multiply and
// accumulate stages, an overflow check plus 32 quotient-bit stages of the divider, and
// the saturation/output register. Throughput is one beat per cycle while no result is
// held; the 32-stage divider sets the depth but not the rate.
// The whole pipeline advances as one: while a result is held by result_stall, item_stall
// is raised and every stage keeps its contents, so nothing is lost or repeated.
// Reset empties the pipeline (all valid bits clear) and loads the default camera:
// center 0, a = (1,0,0), b = (0,-1,0), c = 0, which is singular until c is written.
// Outputs saturate to the signed range of min(COORD_WIDTH, 32) bits, flagging error.
`default_nettype none

module pinhole_point_project import pp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SAT_W = COORD_WIDTH < COORD_W ? COORD_WIDTH : COORD_W;
	localparam int SUM_W = QUO_W + 3;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	cam_t                   cam;
	logic                   adv;
	logic                   front_valid;
	div_in_t [2:0]          front_lanes;
	side_t                  front_side;
	logic                   div_valid;
	logic [2:0][QUO_W-1:0]  div_quo;
	logic [2:0]             div_ovf;
	logic [2:0]             div_neg;
	side_t                  div_side;

	logic                   result_valid_q;
	result_t                result_q;
	result_t                result_c;

	logic signed [SUM_W-1:0]   sq [3];
	logic signed [SUM_W-1:0]   sum [3];
	logic signed [SUM_W-1:0]   clamp [3];
	logic signed [COORD_W-1:0] val [3];
	logic [2:0]                sat;

	// The pipeline moves whenever the output register is free or being drained.
	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = !adv;

	pp_config u_config (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cam    (cam)
	);

	pp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (item_valid),
		.item     (item),
		.cam      (cam),
		.valid    (front_valid),
		.lanes    (front_lanes),
		.side     (front_side)
	);

	pp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (front_valid),
		.lanes    (front_lanes),
		.side_in  (front_side),
		.valid    (div_valid),
		.quo      (div_quo),
		.ovf      (div_ovf),
		.neg      (div_neg),
		.side     (div_side)
	);

	// Apply the sign, add the center for unproject, then clamp. A quotient that did not
	// fit in 32 bits is far outside any output range, so it clamps by its sign alone.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq[i]  = $signed(SUM_W'(div_quo[i]));
			sum[i] = (div_neg[i] ? -sq[i] : sq[i])
				+ ((div_side.kind == KIND_UNPROJECT) ?
					SUM_W'(ctr_off(cam.center, 2'(i))) : SUM_W'(0));
			if (div_ovf[i]) begin
				sat[i]   = 1'b1;
				clamp[i] = div_neg[i] ? SAT_LO : SAT_HI;
			end else if (sum[i] > SAT_HI) begin
				sat[i]   = 1'b1;
				clamp[i] = SAT_HI;
			end else if (sum[i] < SAT_LO) begin
				sat[i]   = 1'b1;
				clamp[i] = SAT_LO;
			end else begin
				sat[i]   = 1'b0;
				clamp[i] = sum[i];
			end
			val[i] = div_side.zero ? '0 : COORD_W'(clamp[i]);
		end
		result_c.visible = div_side.vis;
		result_c.error   = div_side.err || (!div_side.zero && (sat != '0));
		result_c.out_x   = val[0];
		result_c.out_y   = val[1];
		result_c.out_z   = val[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A held result freezes the whole pipe behind it.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |=> $stable(div_valid) && $stable(div_side))
		else $error("pipeline moved while the result was held");

	// Results that are not visible carry zero coordinates.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.visible |->
			result_q.out_x == '0 && result_q.out_y == '0 && result_q.out_z == '0)
		else $error("hidden point with nonzero coordinates");

	// Unproject is always visible.
	a_unproject_vis: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_side.kind == KIND_UNPROJECT |-> div_side.vis)
		else $error("unproject item lost its visible flag");

	// A visible projected point implies a regular camera and a real quotient.
	a_project_vis: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_side.kind == KIND_PROJECT && div_side.vis |->
			!div_side.zero && !div_side.err)
		else $error("visible projection flagged singular");

endmodule

`default_nettype wire

@@ hw/rtl/pp_config.sv @@
// Camera configuration registers and the registered b x c cross product.
`default_nettype none

module pp_config import pp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [CFG_W-1:0]     data,
	output cam_t                 cam
);

	logic [CFG_W-1:0]   center_q;
	logic [CFG_W-1:0]   axis_a_q;
	logic [CFG_W-1:0]   axis_b_q;
	logic [CFG_W-1:0]   corner_q;
	logic [3*BC_W-1:0]  bc_q;
	logic signed [BC_W-1:0] cr [3];
	logic [3*BC_W-1:0]  bc_next;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = fld(axis_b_q, 2'((i + 1) % 3)) * fld(corner_q, 2'((i + 2) % 3))
				- fld(axis_b_q, 2'((i + 2) % 3)) * fld(corner_q, 2'((i + 1) % 3));
			bc_next[BC_W*i +: BC_W] = cr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			axis_a_q <= AXIS_A_RST;
			axis_b_q <= AXIS_B_RST;
			corner_q <= CORNER_RST;
			bc_q     <= '0;
		end else begin
			bc_q <= bc_next;
			if (wr_en) begin
				case (index)
					REG_CENTER: center_q <= data;
					REG_AXIS_A: axis_a_q <= data;
					REG_AXIS_B: axis_b_q <= data;
					REG_CORNER: corner_q <= data;
					default: ;
				endcase
			end
		end
	end

	assign cam.center = center_q;
	assign cam.axis_a = axis_a_q;
	assign cam.axis_b = axis_b_q;
	assign cam.corner = corner_q;
	assign cam.bc     = bc_q;

endmodule

`default_nettype wire

@@ hw/rtl/pp_front.sv @@
// Five-stage multiply front end that builds the divider operands for both item kinds.
`default_nettype none

module pp_front import pp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  item_t            item,
	input  cam_t             cam,
	output logic             valid,
	output div_in_t [2:0]    lanes,
	output side_t            side
);

	localparam int PU_W = FLD_W + COORD_W;
	localparam int PX_W = D_W + BC_W - BC_LO + 1;
	localparam int PD_W = FLD_W + BC_W - BC_LO + 1;
	localparam int PY_W = FLD_W + CR_W - CR_LO + 1;

	function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? -v : v;
	endfunction

	function automatic logic [UP_W-1:0] mag_up(input logic signed [UP_W-1:0] v);
		return v[UP_W-1] ? -v : v;
	endfunction

	function automatic logic [COORD_W-1:0] mag_w(input logic signed [COORD_W-1:0] v);
		return v[COORD_W-1] ? -v : v;
	endfunction

	// Camera fields.
	logic signed [FLD_W-1:0]       va [3];
	logic signed [FLD_W-1:0]       vb [3];
	logic signed [FLD_W-1:0]       vc [3];
	logic signed [OFF_W-1:0]       ccs [3];
	logic signed [BC_W-BC_LO-1:0]  bch [3];
	logic signed [BC_LO:0]         bcl [3];
	logic signed [COORD_W-1:0]     p [3];

	// Stage registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic kind_s1, kind_s2, kind_s3, kind_s4;
	logic signed [D_W-1:0]     d_s1 [3];
	logic signed [PU_W-1:0]    pu_s1 [3];
	logic signed [PU_W-1:0]    pv_s1 [3];
	logic signed [COORD_W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic signed [CR_W-1:0]    dc_s2 [3];
	logic signed [CR_W-1:0]    bd_s2 [3];
	logic signed [PX_W-1:0]    nxh_s2 [3];
	logic signed [PX_W-1:0]    nxl_s2 [3];
	logic signed [PD_W-1:0]    deth_s2 [3];
	logic signed [PD_W-1:0]    detl_s2 [3];
	logic signed [UP_W-1:0]    upn_s2 [3];
	logic signed [UP_W-1:0]    upn_s3 [3];
	logic signed [UP_W-1:0]    upn_s4 [3];
	logic signed [ACC_W-1:0]   nx_s3, det_s3, nx_s4, det_s4, ny_s4, nz_s4;
	logic signed [PY_W-1:0]    nyh_s3 [3];
	logic signed [PY_W-1:0]    nyl_s3 [3];
	logic signed [PY_W-1:0]    nzh_s3 [3];
	logic signed [PY_W-1:0]    nzl_s3 [3];
	div_in_t [2:0]             lanes_s5;
	side_t                     side_s5;

	// Combinational helpers.
	logic signed [ACC_W-1:0]       nx_c, det_c, ny_c, nz_c;
	logic signed [CR_W-CR_LO-1:0]  dch [3];
	logic signed [CR_LO:0]         dcl [3];
	logic signed [CR_W-CR_LO-1:0]  bdh [3];
	logic signed [CR_LO:0]         bdl [3];
	logic [ACC_W-1:0]              mnx, mny, mnz, mdet;
	logic [UP_W-1:0]               mun [3];
	logic [COORD_W-1:0]            mw;
	logic                          detz, wz, vis_p;
	div_in_t [2:0]                 ln_c;
	side_t                         sd_c;

	always_comb begin
		p[0] = item.in_x;
		p[1] = item.in_y;
		p[2] = item.in_z;
		for (int i = 0; i < 3; i++) begin
			va[i]  = fld(cam.axis_a, 2'(i));
			vb[i]  = fld(cam.axis_b, 2'(i));
			vc[i]  = fld(cam.corner, 2'(i));
			ccs[i] = ctr_off(cam.center, 2'(i));
			bch[i] = $signed(cam.bc[BC_W*i+BC_LO +: BC_W-BC_LO]);
			bcl[i] = $signed({1'b0, cam.bc[BC_W*i +: BC_LO]});
		end
	end

	// Partial products of the dot products are split so no multiplier exceeds about 33 bits.
	always_comb begin
		nx_c  = '0;
		det_c = '0;
		ny_c  = '0;
		nz_c  = '0;
		for (int i = 0; i < 3; i++) begin
			nx_c  = nx_c + (ACC_W'(nxh_s2[i]) <<< BC_LO) + ACC_W'(nxl_s2[i]);
			det_c = det_c + (ACC_W'(deth_s2[i]) <<< BC_LO) + ACC_W'(detl_s2[i]);
			ny_c  = ny_c + (ACC_W'(nyh_s3[i]) <<< CR_LO) + ACC_W'(nyl_s3[i]);
			nz_c  = nz_c + (ACC_W'(nzh_s3[i]) <<< CR_LO) + ACC_W'(nzl_s3[i]);
			dch[i] = $signed(dc_s2[i][CR_W-1:CR_LO]);
			dcl[i] = $signed({1'b0, dc_s2[i][CR_LO-1:0]});
			bdh[i] = $signed(bd_s2[i][CR_W-1:CR_LO]);
			bdl[i] = $signed({1'b0, bd_s2[i][CR_LO-1:0]});
		end
	end

	// Rounded division is done on magnitudes: num = 2|n| + |d|, den = 2|d|.
	always_comb begin
		detz  = det_s4 == '0;
		vis_p = !detz && (nz_s4 != '0) && (nz_s4[ACC_W-1] == det_s4[ACC_W-1]);
		mnx   = mag_acc(nx_s4);
		mny   = mag_acc(ny_s4);
		mnz   = mag_acc(nz_s4);
		mdet  = mag_acc(det_s4);
		mw    = mag_w(w_s4);
		wz    = w_s4 == '0;
		for (int i = 0; i < 3; i++) begin
			mun[i] = mag_up(upn_s4[i]);
		end
		if (kind_s4 == KIND_PROJECT) begin
			ln_c[0].num = (NUM_W'(mnx) << NX_SH) + NUM_W'(mnz);
			ln_c[0].den = DEN_W'(mnz << 1);
			ln_c[0].neg = nx_s4[ACC_W-1] ^ nz_s4[ACC_W-1];
			ln_c[1].num = (NUM_W'(mny) << NX_SH) + NUM_W'(mnz);
			ln_c[1].den = DEN_W'(mnz << 1);
			ln_c[1].neg = ny_s4[ACC_W-1] ^ nz_s4[ACC_W-1];
			ln_c[2].num = (NUM_W'(mdet) << DET_SH) + NUM_W'(mnz);
			ln_c[2].den = DEN_W'(mnz << 1);
			ln_c[2].neg = det_s4[ACC_W-1] ^ nz_s4[ACC_W-1];
			sd_c.kind   = KIND_PROJECT;
			sd_c.vis    = vis_p;
			sd_c.err    = detz;
			sd_c.zero   = !vis_p;
		end else begin
			for (int i = 0; i < 3; i++) begin
				ln_c[i].num = (NUM_W'(mun[i]) << 1) + NUM_W'(mw);
				ln_c[i].den = DEN_W'(mw) << 1;
				ln_c[i].neg = upn_s4[i][UP_W-1] ^ w_s4[COORD_W-1];
			end
			sd_c.kind = KIND_UNPROJECT;
			sd_c.vis  = 1'b1;
			sd_c.err  = wz;
			sd_c.zero = wz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: d = P - C and the unproject products a*u, b*v.
			kind_s1 <= item.kind;
			w_s1    <= item.in_z;
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= D_W'(p[i]) - D_W'(ccs[i]);
				pu_s1[i] <= va[i] * p[0];
				pv_s1[i] <= vb[i] * p[1];
			end
			// Stage 2: cross products and dot-product partials for nx and det.
			kind_s2 <= kind_s1;
			w_s2    <= w_s1;
			for (int i = 0; i < 3; i++) begin
				dc_s2[i] <= d_s1[(i+1)%3] * vc[(i+2)%3] - d_s1[(i+2)%3] * vc[(i+1)%3];
				bd_s2[i] <= vb[(i+1)%3] * d_s1[(i+2)%3] - vb[(i+2)%3] * d_s1[(i+1)%3];
				nxh_s2[i]  <= d_s1[i] * bch[i];
				nxl_s2[i]  <= d_s1[i] * bcl[i];
				deth_s2[i] <= va[i] * bch[i];
				detl_s2[i] <= va[i] * bcl[i];
				upn_s2[i]  <= ((UP_W'(pu_s1[i]) + UP_W'(pv_s1[i])) <<< 1)
					+ (UP_W'(vc[i]) <<< UP_SH);
			end
			// Stage 3: sum nx and det, partials for ny and nz.
			kind_s3 <= kind_s2;
			w_s3    <= w_s2;
			nx_s3   <= nx_c;
			det_s3  <= det_c;
			for (int i = 0; i < 3; i++) begin
				nyh_s3[i] <= va[i] * dch[i];
				nyl_s3[i] <= va[i] * dcl[i];
				nzh_s3[i] <= va[i] * bdh[i];
				nzl_s3[i] <= va[i] * bdl[i];
				upn_s3[i] <= upn_s2[i];
			end
			// Stage 4: sum ny and nz.
			kind_s4 <= kind_s3;
			w_s4    <= w_s3;
			nx_s4   <= nx_s3;
			det_s4  <= det_s3;
			ny_s4   <= ny_c;
			nz_s4   <= nz_c;
			for (int i = 0; i < 3; i++) begin
				upn_s4[i] <= upn_s3[i];
			end
			// Stage 5: divider operands and flags.
			lanes_s5 <= ln_c;
			side_s5  <= sd_c;
		end
	end

	assign valid = v_s5;
	assign lanes = lanes_s5;
	assign side  = side_s5;

endmodule

`default_nettype wire

@@ hw/rtl/pp_divider.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage plus an overflow stage.
`default_nettype none

module pp_divider import pp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  div_in_t [2:0]           lanes,
	input  side_t                   side_in,
	output logic                    valid,
	output logic [2:0][QUO_W-1:0]   quo,
	output logic [2:0]              ovf,
	output logic [2:0]              neg,
	output side_t                   side
);

	localparam int XW = DEN_W + QUO_W;

	logic                   v_s    [0:QUO_W];
	side_t                  side_s [0:QUO_W];
	logic [2:0]             ovf_s  [0:QUO_W];
	logic [2:0]             neg_s  [0:QUO_W];
	logic [2:0][QUO_W-1:0]  quo_s  [0:QUO_W];
	logic [2:0][NUM_W-1:0]  rem_s  [0:QUO_W];
	logic [2:0][DEN_W-1:0]  den_s  [0:QUO_W];
	logic [2:0][XW:0]       diff   [1:QUO_W];

	// Stage k tries to subtract den shifted by QUO_W - k.
	always_comb begin
		for (int k = 1; k <= QUO_W; k++) begin
			for (int l = 0; l < 3; l++) begin
				diff[k][l] = {1'b0, XW'(rem_s[k-1][l])}
					- {1'b0, XW'(den_s[k-1][l]) << (QUO_W - k)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int k = 1; k <= QUO_W; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			quo_s[0]  <= '0;
			for (int l = 0; l < 3; l++) begin
				ovf_s[0][l] <= XW'(lanes[l].num) >= (XW'(lanes[l].den) << QUO_W);
				neg_s[0][l] <= lanes[l].neg;
				rem_s[0][l] <= lanes[l].num;
				den_s[0][l] <= lanes[l].den;
			end
			for (int k = 1; k <= QUO_W; k++) begin
				side_s[k] <= side_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				for (int l = 0; l < 3; l++) begin
					quo_s[k][l] <= {quo_s[k-1][l][QUO_W-2:0], !diff[k][l][XW]};
					rem_s[k][l] <= diff[k][l][XW] ? rem_s[k-1][l] : diff[k][l][NUM_W-1:0];
					den_s[k][l] <= den_s[k-1][l];
				end
			end
		end
	end

	assign valid = v_s[QUO_W];
	assign quo   = quo_s[QUO_W];
	assign ovf   = ovf_s[QUO_W];
	assign neg   = neg_s[QUO_W];
	assign side  = side_s[QUO_W];

endmodule

`default_nettype wire

@@ tb/sv/pinhole_point_project_tb.sv @@
// Self-checking testbench for the pinhole camera projection block.
`timescale 1ns / 100ps
`default_nettype none

module pinhole_point_project_tb;
	import pp_pkg::*;

	localparam int LATENCY   = 38;
	localparam int N_RANDOM  = 1250;
	localparam int MAX_CYCLES = 400000;
	localparam int SAT_W     = 32;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pinhole_point_project #(.COORD_WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The predictor keeps its own copy of the four camera registers.
	logic [CFG_W-1:0] cam_reg [4];

	// Results still owed by the block, oldest first.
	result_t pending_results[$];

	int  mismatches;
	int  results_seen;
	int  beats_sent;
	int  cycle_count;
	bit  rx_idle_en;

	// Directed stimulus rows; an expectation is typed in only where it is obvious.
	typedef struct {
		item_t   beat;
		bit      has_fixed;
		result_t fixed;
	} stim_row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// Predictor. All arithmetic is done on wide signed vectors so that every
	// intermediate product of the camera solve is exact.
	// ---------------------------------------------------------------------------
	function automatic logic signed [20:0] cam_field(input logic [CFG_W-1:0] r, input int i);
		return $signed(r[21*i +: 21]);
	endfunction

	// Round to nearest with ties away from zero; the divisor is nonzero.
	function automatic logic signed [199:0] div_nearest(input logic signed [199:0] n,
		input logic signed [199:0] d);
		logic signed [199:0] mn, md, q;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q  = (2 * mn + md) / (2 * md);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	// Clamp to the output range; any clamping raises the error flag.
	function automatic logic [31:0] clamp_coord(input logic signed [199:0] v, inout bit err);
		logic signed [199:0] hi_b, lo_b;
		hi_b = (200'sd1 <<< (SAT_W - 1)) - 1;
		lo_b = -(200'sd1 <<< (SAT_W - 1));
		if (v > hi_b) begin
			err = 1'b1;
			return hi_b[31:0];
		end
		if (v < lo_b) begin
			err = 1'b1;
			return lo_b[31:0];
		end
		return v[31:0];
	endfunction

	function automatic result_t camera_solve(input item_t it);
		logic signed [199:0] cc[3], va[3], vb[3], vc[3], p[3], d[3];
		logic signed [199:0] bc[3], dc[3], bd[3];
		logic signed [199:0] det, nx, ny, nz, n, q;
		result_t r;
		bit err;
		err = 1'b0;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			cc[i] = cam_field(cam_reg[REG_CENTER], i);
			va[i] = cam_field(cam_reg[REG_AXIS_A], i);
			vb[i] = cam_field(cam_reg[REG_AXIS_B], i);
			vc[i] = cam_field(cam_reg[REG_CORNER], i);
		end
		p[0] = it.in_x;
		p[1] = it.in_y;
		p[2] = it.in_z;
		if (it.kind == KIND_PROJECT) begin
			for (int i = 0; i < 3; i++) d[i] = p[i] - cc[i] * 256;
			bc[0] = vb[1]*vc[2] - vb[2]*vc[1];
			bc[1] = vb[2]*vc[0] - vb[0]*vc[2];
			bc[2] = vb[0]*vc[1] - vb[1]*vc[0];
			dc[0] = d[1]*vc[2] - d[2]*vc[1];
			dc[1] = d[2]*vc[0] - d[0]*vc[2];
			dc[2] = d[0]*vc[1] - d[1]*vc[0];
			bd[0] = vb[1]*d[2] - vb[2]*d[1];
			bd[1] = vb[2]*d[0] - vb[0]*d[2];
			bd[2] = vb[0]*d[1] - vb[1]*d[0];
			det = va[0]*bc[0] + va[1]*bc[1] + va[2]*bc[2];
			nx  = d[0]*bc[0] + d[1]*bc[1] + d[2]*bc[2];
			ny  = va[0]*dc[0] + va[1]*dc[1] + va[2]*dc[2];
			nz  = va[0]*bd[0] + va[1]*bd[1] + va[2]*bd[2];
			if (det == 0) begin
				err = 1'b1;
			end else if (nz != 0 && ((nz < 0) == (det < 0))) begin
				r.visible = 1'b1;
				r.out_x = clamp_coord(div_nearest(nx <<< 23, nz), err);
				r.out_y = clamp_coord(div_nearest(ny <<< 23, nz), err);
				r.out_z = clamp_coord(div_nearest(det <<< 24, nz), err);
			end
		end else begin
			r.visible = 1'b1;
			if (p[2] == 0) begin
				err = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					n = 2 * (va[i]*p[0] + vb[i]*p[1]) + vc[i] * 16777216;
					q = div_nearest(n, p[2]) + cc[i] * 256;
					case (i)
						0: r.out_x = clamp_coord(q, err);
						1: r.out_y = clamp_coord(q, err);
						default: r.out_z = clamp_coord(q, err);
					endcase
				end
			end
		end
		r.error = err;
		return r;
	endfunction

	// Packs three signed 21-bit fields into one register value.
	function automatic logic [CFG_W-1:0] pack_vec(input int x, input int y, input int z);
		logic [20:0] fx, fy, fz;
		fx = x[20:0];
		fy = y[20:0];
		fz = z[20:0];
		return {fz, fy, fx};
	endfunction

	// ---------------------------------------------------------------------------
	// Result side: random stalls, except for a long stretch with none, and a
	// field-by-field compare against the oldest expectation.
	// ---------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= rx_idle_en && ($urandom_range(99) < 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			result_t exp_r;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result beat with nothing expected: %p", result);
			end else begin
				exp_r = pending_results.pop_front();
				if (result.visible !== exp_r.visible || result.error !== exp_r.error ||
						result.out_x !== exp_r.out_x || result.out_y !== exp_r.out_y ||
						result.out_z !== exp_r.out_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result %0d expected vis=%0b err=%0b %h %h %h, got vis=%0b err=%0b %h %h %h",
							results_seen, exp_r.visible, exp_r.error, exp_r.out_x,
							exp_r.out_y, exp_r.out_z, result.visible, result.error,
							result.out_x, result.out_y, result.out_z);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------
	// Item side helpers.
	// ---------------------------------------------------------------------------

	// Presents one beat, with an optional random idle gap first, and holds it
	// until the block takes it. Expectations are queued at the accepting edge.
	task automatic send_beat(input item_t it, input bit gaps, input bit has_fixed,
		input result_t fixed);
		result_t pred;
		if (gaps) begin
			while ($urandom_range(99) < 12) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item       <= it;
		pred = camera_solve(it);
		if (has_fixed && pred !== fixed)
			$display("Note: typed expectation differs from prediction for %p", it);
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_results.push_back(has_fixed ? fixed : pred);
		beats_sent++;
	endtask

	// Waits until the block has returned every owed result, then lets the
	// pipeline drain before anything else happens.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		cam_reg[idx] = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_camera(input logic [CFG_W-1:0] c_reg, input logic [CFG_W-1:0] a_reg,
		input logic [CFG_W-1:0] b_reg, input logic [CFG_W-1:0] k_reg);
		write_reg(REG_CENTER, c_reg);
		write_reg(REG_AXIS_A, a_reg);
		write_reg(REG_AXIS_B, b_reg);
		write_reg(REG_CORNER, k_reg);
	endtask

	// Random beat: mostly sensible scene points or pixels, sometimes raw noise.
	function automatic item_t random_beat();
		item_t it;
		int sel;
		sel = $urandom_range(99);
		it.kind = 1'($urandom_range(1));
		if (sel < 20) begin
			it.in_x = $urandom;
			it.in_y = $urandom;
			it.in_z = $urandom;
		end else if (it.kind == KIND_PROJECT) begin
			it.in_x = $signed($urandom_range(2000000)) - 1000000;
			it.in_y = $signed($urandom_range(2000000)) - 1000000;
			it.in_z = $signed($urandom_range(4000000)) - 1000000;
		end else begin
			it.in_x = $urandom_range(1 << 26);
			it.in_y = $urandom_range(1 << 26);
			it.in_z = (sel < 25) ? 32'sd0 : $signed($urandom_range(131072)) - 16384;
		end
		return it;
	endfunction

	// Random camera: small sensible axes most of the time, raw bits otherwise.
	task automatic random_camera(input bit raw);
		if (raw) begin
			load_camera(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
				CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}));
		end else begin
			load_camera(
				pack_vec($signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(8192)) - 4096),
				pack_vec($signed($urandom_range(65536)) - 16384,
					$signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(8192)) - 4096),
				pack_vec($signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(65536)) - 16384,
					$signed($urandom_range(8192)) - 4096),
				pack_vec($signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(8192)) - 4096,
					$signed($urandom_range(4096)) + 256));
		end
	endtask

	// ---------------------------------------------------------------------------
	// Main sequence.
	// ---------------------------------------------------------------------------
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		result_t zero_r;
		logic [CFG_W-1:0] max_pos, max_neg;

		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		mismatches   = 0;
		results_seen = 0;
		beats_sent   = 0;
		cycle_count  = 0;
		rx_idle_en   = 1'b1;
		cam_reg[REG_CENTER] = CENTER_RST;
		cam_reg[REG_AXIS_A] = AXIS_A_RST;
		cam_reg[REG_AXIS_B] = AXIS_B_RST;
		cam_reg[REG_CORNER] = CORNER_RST;
		zero_r = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset camera has a zero corner vector and is singular: projecting
		// flags error with zero outputs, unprojecting still works.
		row.has_fixed = 1'b1;
		row.fixed = zero_r;
		row.fixed.error = 1'b1;
		row.beat = '{KIND_PROJECT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000};
		rows.push_back(row);
		row.beat = '{KIND_PROJECT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
		rows.push_back(row);
		// Zero inverse depth on unproject.
		row.fixed.visible = 1'b1;
		row.beat = '{KIND_UNPROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0};
		rows.push_back(row);
		// Unit inverse depth: world point is (u, -v, 0).
		row.fixed = '{1'b1, 1'b0, 32'sh0003_0000, -32'sh0002_0000, 32'sh0};
		row.beat = '{KIND_UNPROJECT, 32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000};
		rows.push_back(row);
		row.has_fixed = 1'b0;
		row.beat = '{KIND_UNPROJECT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001};
		rows.push_back(row);
		row.beat = '{KIND_UNPROJECT, 32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff};
		rows.push_back(row);
		row.beat = '{KIND_UNPROJECT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		rows.push_back(row);
		foreach (rows[i]) send_beat(rows[i].beat, 1'b0, rows[i].has_fixed, rows[i].fixed);
		wait_drained();

		// A usable camera: c = (0,0,1), so points with z > 0 are in front.
		write_reg(REG_CORNER, pack_vec(0, 0, 256));
		rows.delete();
		row.has_fixed = 1'b1;
		// Point in the camera plane and point behind it: not visible, no error.
		row.fixed = zero_r;
		row.beat = '{KIND_PROJECT, 32'sh0005_0000, 32'sh0005_0000, 32'sh0};
		rows.push_back(row);
		row.beat = '{KIND_PROJECT, 32'sh0005_0000, 32'sh0005_0000, -32'sh0001_0000};
		rows.push_back(row);
		// Point at depth one projects to (x, -y) with unit inverse depth.
		row.fixed = '{1'b1, 1'b0, 32'sh0004_0000, -32'sh0002_0000, 32'sh0001_0000};
		row.beat = '{KIND_PROJECT, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000};
		rows.push_back(row);
		row.has_fixed = 1'b0;
		// Tiny depth: the quotients saturate.
		row.beat = '{KIND_PROJECT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001};
		rows.push_back(row);
		row.beat = '{KIND_PROJECT, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
		rows.push_back(row);
		row.beat = '{KIND_PROJECT, 32'sh0000_8000, 32'shffff_8000, 32'sh0003_0000};
		rows.push_back(row);
		row.beat = '{KIND_UNPROJECT, 32'sh0010_0000, 32'sh0020_0000, 32'sh0000_8000};
		rows.push_back(row);
		foreach (rows[i]) send_beat(rows[i].beat, 1'b1, rows[i].has_fixed, rows[i].fixed);
		wait_drained();

		// Extreme register values: every field at its positive and negative limit.
		max_pos = pack_vec(32'hf_ffff, 32'hf_ffff, 32'hf_ffff);
		max_neg = pack_vec(32'h10_0000, 32'h10_0000, 32'h10_0000);
		load_camera(max_pos, max_neg, pack_vec(32'hf_ffff, 32'h10_0000, 0), max_pos);
		send_beat('{KIND_PROJECT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, 0, zero_r);
		send_beat('{KIND_PROJECT, 32'sh7fff_ffff, 32'sh0, 32'sh8000_0000}, 1'b0, 0, zero_r);
		send_beat('{KIND_UNPROJECT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh1}, 1'b0, 0, zero_r);
		wait_drained();
		load_camera(max_neg, pack_vec(32'h10_0000, 1, 2), pack_vec(3, 32'hf_ffff, 4),
			pack_vec(5, 6, 32'h10_0000));
		send_beat('{KIND_PROJECT, 32'sh1234_5678, -32'sh0765_4321, 32'sh7fff_0000}, 1'b0, 0, zero_r);
		send_beat('{KIND_UNPROJECT, -32'sh1, 32'sh1, -32'sh0001_0000}, 1'b0, 0, zero_r);
		wait_drained();

		// Random part: camera changes between phases. The first phase runs with
		// no idling on either side; one phase pauses the sender until drained.
		for (int phase = 0; phase < 10; phase++) begin
			random_camera(phase == 9);
			rx_idle_en = (phase != 0);
			for (int k = 0; k < N_RANDOM / 10; k++) begin
				send_beat(random_beat(), phase != 0, 1'b0, zero_r);
				if (phase == 4 && k == 60) wait_drained();
			end
			wait_drained();
		end

		$display("Covered %0d beats over reset, extreme and random cameras,", beats_sent);
		$display("including singular, behind-camera, zero-depth and saturating cases.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				pending_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
